// ===== hdl/arfe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and the CRC-8 step for the register frame engine.
// No dependencies.
package arfe_pkg;

	localparam int MAX_REG_BYTES = 3;
	localparam int VALUE_W = 24;

	localparam logic [7:0] READ_FLAG = 8'h40;
	localparam logic [7:0] CRC_SEED = 8'h00;
	localparam logic [7:0] CRC_POLY_RESET = 8'h07;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_RX    = 2'd2
	} cmd_t;

	typedef enum logic {
		CFG_CRC_ENABLE = 1'b0,
		CFG_CRC_POLY   = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		JOB_WRITE = 2'd0,
		JOB_READ  = 2'd1,
		JOB_DONE  = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t           kind;
		logic [7:0]          cmd_byte;
		logic [VALUE_W-1:0]  value;
		logic [1:0]          nbytes;
		logic                crc_on;
		logic                err;
	} job_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
	                                         input logic [7:0] data,
	                                         input logic [7:0] poly);
		logic [7:0] crc;
		logic       top;
		crc = crc_in;
		for (int b = 7; b >= 0; b--) begin
			top = crc[7];
			crc = {crc[6:0], 1'b0};
			if (top != data[b]) begin
				crc = crc ^ poly;
			end
		end
		return crc;
	endfunction

endpackage

// ===== hdl/arfe_req_if.sv =====
`timescale 1ns / 1ps
// Input item channel: access requests and received bytes.
// Depends on arfe_pkg.
interface arfe_req_if;
	import arfe_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic [5:0]         address;
	logic [1:0]         byte_count;
	logic [VALUE_W-1:0] write_value;
	logic [7:0]         rx_byte;

	modport source (output valid, command, address, byte_count, write_value, rx_byte,
		input ready);
	modport sink (input valid, command, address, byte_count, write_value, rx_byte,
		output ready);
endinterface

// ===== hdl/arfe_rsp_if.sv =====
`timescale 1ns / 1ps
// Result item channel: bytes to transmit and read completions.
// Depends on arfe_pkg.
interface arfe_rsp_if;
	import arfe_pkg::*;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [7:0]         tx_byte;
	logic               last;
	logic [VALUE_W-1:0] read_value;
	logic               crc_error;

	modport source (output valid, kind, tx_byte, last, read_value, crc_error,
		input ready);
	modport sink (input valid, kind, tx_byte, last, read_value, crc_error,
		output ready);
endinterface

// ===== hdl/arfe_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel: register index and data.
// No dependencies.
interface arfe_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/arfe_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts items, tracks the pending read and its CRC, and queues jobs.
// Depends on arfe_pkg and arfe_req_if.
module arfe_front (
	input  logic           clk,
	input  logic           arst_n,
	arfe_req_if.sink       req,
	input  logic           crc_en,
	input  logic [7:0]     crc_poly,
	input  logic           q_full,
	output logic           push,
	output arfe_pkg::job_t push_job
);
	import arfe_pkg::*;

	logic               read_pending_q;
	logic [2:0]         bytes_expected_q;
	logic [2:0]         bytes_received_q;
	logic [7:0]         running_crc_q;
	logic [VALUE_W-1:0] assembled_q;

	cmd_t               cmd;
	logic               accept;
	logic [1:0]         n_sat;
	logic [7:0]         rd_cb;
	logic [7:0]         crc_rx;
	logic [2:0]         data_count;
	logic [2:0]         recv_next;
	logic               rx_done;
	logic [VALUE_W-1:0] value_next;
	logic               rx_err;

	assign cmd = cmd_t'(req.command);
	assign req.ready = !q_full;
	assign accept = req.valid && req.ready;
	assign rd_cb = READ_FLAG | {2'b00, req.address};

	always_comb begin
		n_sat = (req.byte_count == 2'd0) ? 2'd1 : req.byte_count;
		if ({1'b0, n_sat} > 3'(MAX_REG_BYTES)) begin
			n_sat = 2'(MAX_REG_BYTES);
		end
	end

	assign crc_rx = crc8_byte(running_crc_q, req.rx_byte, crc_poly);
	assign data_count = (bytes_expected_q > {2'b00, crc_en}) ?
		(bytes_expected_q - {2'b00, crc_en}) : 3'd0;
	assign recv_next = bytes_received_q + 3'd1;
	assign rx_done = recv_next >= bytes_expected_q;
	assign value_next = (bytes_received_q < data_count) ?
		{assembled_q[VALUE_W-9:0], req.rx_byte} : assembled_q;
	assign rx_err = crc_en && (crc_rx != 8'h00);

	always_comb begin
		push = 1'b0;
		push_job.kind = JOB_WRITE;
		push_job.cmd_byte = {2'b00, req.address};
		push_job.value = req.write_value;
		push_job.nbytes = n_sat;
		push_job.crc_on = crc_en;
		push_job.err = 1'b0;
		case (cmd)
			CMD_WRITE: begin
				push = accept;
			end
			CMD_READ: begin
				push = accept;
				push_job.kind = JOB_READ;
				push_job.cmd_byte = rd_cb;
			end
			CMD_RX: begin
				push = accept && read_pending_q && rx_done;
				push_job.kind = JOB_DONE;
				push_job.err = rx_err;
				push_job.value = rx_err ? '0 : value_next;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_pending_q <= 1'b0;
			bytes_expected_q <= 3'd0;
			bytes_received_q <= 3'd0;
			running_crc_q <= 8'h00;
			assembled_q <= '0;
		end else if (accept) begin
			case (cmd)
				CMD_WRITE: begin
					read_pending_q <= 1'b0;
				end
				CMD_READ: begin
					read_pending_q <= 1'b1;
					bytes_expected_q <= {1'b0, n_sat} + {2'b00, crc_en};
					bytes_received_q <= 3'd0;
					running_crc_q <= crc8_byte(CRC_SEED, rd_cb, crc_poly);
					assembled_q <= '0;
				end
				CMD_RX: begin
					if (read_pending_q) begin
						running_crc_q <= crc_rx;
						assembled_q <= value_next;
						bytes_received_q <= recv_next;
						if (rx_done) begin
							read_pending_q <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== hdl/arfe_queue.sv =====
`timescale 1ns / 1ps
// Short job queue between the front end and the byte sequencer.
// Depends on arfe_pkg.
module arfe_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  arfe_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output arfe_pkg::job_t head_job
);
	import arfe_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = count_q == CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_job = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/arfe_back.sv =====
`timescale 1ns / 1ps
// Back end: turns queued jobs into result items, one per cycle unless stalled,
// with a CRC over the sent write bytes. Depends on arfe_pkg and arfe_rsp_if.
module arfe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     crc_poly,
	input  logic           head_valid,
	input  arfe_pkg::job_t head_job,
	output logic           pop,
	arfe_rsp_if.source     rsp
);
	import arfe_pkg::*;

	logic       active_q;
	job_t       job_q;
	logic [2:0] idx_q;
	logic [7:0] crc_q;

	logic               out_valid_q;
	logic               kind_q;
	logic [7:0]         tx_byte_q;
	logic               last_q;
	logic [VALUE_W-1:0] read_value_q;
	logic               crc_error_q;

	logic       emit;
	logic [2:0] final_idx;
	logic       is_final;
	logic [1:0] shift_sel;
	logic [7:0] value_byte;
	logic [7:0] cur_byte;
	logic [7:0] crc_base;

	assign final_idx = (job_q.kind == JOB_DONE) ? 3'd0 :
		{1'b0, job_q.nbytes} + {2'b00, job_q.crc_on};
	assign is_final = idx_q == final_idx;
	assign emit = active_q && (!out_valid_q || rsp.ready);
	assign pop = head_valid && (!active_q || (emit && is_final));
	assign shift_sel = job_q.nbytes - idx_q[1:0];

	always_comb begin
		case (shift_sel)
			2'd0: value_byte = job_q.value[7:0];
			2'd1: value_byte = job_q.value[15:8];
			2'd2: value_byte = job_q.value[23:16];
			default: value_byte = 8'h00;
		endcase
	end

	always_comb begin
		cur_byte = 8'h00;
		case (job_q.kind)
			JOB_WRITE: begin
				if (idx_q == 3'd0) begin
					cur_byte = job_q.cmd_byte;
				end else if (idx_q <= {1'b0, job_q.nbytes}) begin
					cur_byte = value_byte;
				end else begin
					cur_byte = crc_q;
				end
			end
			JOB_READ: begin
				cur_byte = (idx_q == 3'd0) ? job_q.cmd_byte : 8'h00;
			end
			default: begin
				cur_byte = 8'h00;
			end
		endcase
	end

	assign crc_base = (idx_q == 3'd0) ? CRC_SEED : crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q <= 3'd0;
		end else if (pop) begin
			active_q <= 1'b1;
			idx_q <= 3'd0;
		end else if (emit && is_final) begin
			active_q <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
		if (emit) begin
			crc_q <= crc8_byte(crc_base, cur_byte, crc_poly);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (job_q.kind == JOB_DONE) begin
				kind_q <= 1'b1;
				tx_byte_q <= 8'h00;
				last_q <= 1'b0;
				read_value_q <= job_q.value;
				crc_error_q <= job_q.err;
			end else begin
				kind_q <= 1'b0;
				tx_byte_q <= cur_byte;
				last_q <= is_final;
				read_value_q <= '0;
				crc_error_q <= 1'b0;
			end
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.kind = kind_q;
	assign rsp.tx_byte = tx_byte_q;
	assign rsp.last = last_q;
	assign rsp.read_value = read_value_q;
	assign rsp.crc_error = crc_error_q;

endmodule

// ===== hdl/adc_register_frame_engine_core.sv =====
`timescale 1ns / 1ps
// Register frame engine top: configuration registers, front end, job queue, back end.
// Items pass the job queue, the back end's job register and its output register.
// Throughput: one result item per cycle while rsp is ready; an access gives 2 to 5 items
// (one per frame byte), a read completion one; input takes one item a cycle while the
// two-entry job queue has room. Reset clears all control state, CRC off, poly 7.
module adc_register_frame_engine_core (
	input  logic       clk,
	input  logic       arst_n,
	arfe_req_if.sink   req,
	arfe_rsp_if.source rsp,
	arfe_cfg_if.sink   cfg
);
	import arfe_pkg::*;

	logic       crc_enable_q;
	logic [7:0] crc_poly_q;

	logic q_full;
	logic push;
	job_t push_job;
	logic pop;
	logic head_valid;
	job_t head_job;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_enable_q <= 1'b0;
			crc_poly_q <= CRC_POLY_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_idx_t'(cfg.index))
				CFG_CRC_ENABLE: crc_enable_q <= cfg.data[0];
				CFG_CRC_POLY:   crc_poly_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	arfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.crc_en   (crc_enable_q),
		.crc_poly (crc_poly_q),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	arfe_queue #(
		.DEPTH (2)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	arfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.crc_poly   (crc_poly_q),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule

// ===== hdl/arfe_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the register frame engine, bound to the top level.
// Depends on arfe_pkg and the top level's channels.
module arfe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_kind,
	input logic [7:0]  rsp_tx_byte,
	input logic        rsp_last,
	input logic [23:0] rsp_read_value,
	input logic        rsp_crc_error
);
	import arfe_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte)
			&& $stable(rsp_kind) && $stable(rsp_read_value))
		else $error("result item changed while stalled");

	a_done_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind |-> rsp_tx_byte == 8'h00 && !rsp_last)
		else $error("read completion carries transmit fields");

	a_byte_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_kind |-> rsp_read_value == '0 && !rsp_crc_error)
		else $error("transmit byte carries completion fields");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_crc_error |-> rsp_read_value == '0)
		else $error("read value not cleared on CRC error");

endmodule

bind adc_register_frame_engine_core arfe_checker u_arfe_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_kind       (rsp.kind),
	.rsp_tx_byte    (rsp.tx_byte),
	.rsp_last       (rsp.last),
	.rsp_read_value (rsp.read_value),
	.rsp_crc_error  (rsp.crc_error)
);
